// ===== hw/rtl/tlf_pkg.sv =====
package tlf_pkg;

    // number format and index width
    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int INDEX_WIDTH = 16;

    // divider: dividend magnitude is |num| << FRAC_BITS
    localparam int NUM_W = DATA_WIDTH + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    // multiplier product and accumulator of two shifted products
    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int ACC_W  = PROD_W - FRAC_BITS + 1;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [INDEX_WIDTH-1:0]       t_index;

    localparam t_data DATA_MAX = t_data'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam t_data DATA_MIN = t_data'({1'b1, {(DATA_WIDTH-1){1'b0}}});

    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(DATA_MAX);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(DATA_MIN);

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FAIL = 2'd1,
        STAT_SKIP = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIVOT,
        ST_DRE_GO,
        ST_DRE_WAIT,
        ST_DIM_GO,
        ST_DIM_WAIT,
        ST_MUL_RE,
        ST_MUL_IM,
        ST_ACC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_clr;
    } t_mac_ctl;

    // saturate a one-bit-grown difference
    function automatic t_data sat_diff(input logic signed [DATA_WIDTH:0] x);
        t_data r;
        if (x[DATA_WIDTH] != x[DATA_WIDTH-1]) begin
            r = x[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
        end else begin
            r = x[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    // saturate the product accumulator
    function automatic t_data sat_acc(input logic signed [ACC_W-1:0] x);
        t_data r;
        if (x > ACC_MAX) begin
            r = DATA_MAX;
        end else if (x < ACC_MIN) begin
            r = DATA_MIN;
        end else begin
            r = x[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/tridiagonal_ldlh_factor_stream.sv =====
// channel   direction  handshake          payload
// rows in   input      i_valid / o_stall  i_diag_in, i_offdiag_re, i_offdiag_im, i_last
// rows out  output     o_valid / i_stall  o_pivot_out, o_mult_re, o_mult_im, o_status,
//                                         o_fail_index, o_last_out
//
// a normal row: pivot, then two 48-step restoring divisions on the shared divider,
// then the shared multiplier and accumulate, then the result is loaded in the emit state
// failed, skipped and last rows take no divide: they go from the pivot state to the emit state
// the block takes one row at a time; the next input transfer can come in the cycle after the load
// synchronous active-low reset clears the sequencer, carry, row count and failure mark
// o_stall is high from transfer until the result is loaded into the output register;
// a held result does not block the next input transfer, only the next load
module tridiagonal_ldlh_factor_stream (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  tlf_pkg::t_data   i_diag_in,
    input  tlf_pkg::t_data   i_offdiag_re,
    input  tlf_pkg::t_data   i_offdiag_im,
    input  logic             i_last,
    output logic             o_valid,
    input  logic             i_stall,
    output tlf_pkg::t_data   o_pivot_out,
    output tlf_pkg::t_data   o_mult_re,
    output tlf_pkg::t_data   o_mult_im,
    output tlf_pkg::t_status o_status,
    output tlf_pkg::t_index  o_fail_index,
    output logic             o_last_out
);
    import tlf_pkg::*;

    t_state  r_state;
    t_state  n_state;

    // recurrence state
    t_data   r_carry;
    t_index  r_row_count;
    t_index  r_failed;

    // row being worked on
    t_data   r_diag;
    t_data   r_er;
    t_data   r_ei;
    logic    r_last;
    t_data   r_pivot;
    t_data   r_mr;
    t_data   r_mi;
    t_status r_status;

    // output register
    logic    r_ovalid;
    t_data   r_o_pivot;
    t_data   r_o_mr;
    t_data   r_o_mi;
    t_status r_o_status;
    t_index  r_o_fail;
    logic    r_o_last;

    logic     w_accept;
    logic     w_out_free;
    logic     w_div_start;
    logic     w_sel_im;
    t_mac_ctl w_mac_ctl;
    logic     w_div_done;
    t_data    w_quot;
    t_data    w_sum;
    t_data    w_piv;
    logic     w_piv_pos;
    t_data    w_div_num;
    t_data    w_mac_a;
    t_data    w_mac_b;

    assign o_stall    = (r_state != ST_IDLE) | !i_rst_n;
    assign w_accept   = i_valid & ~o_stall;
    assign w_out_free = ~r_ovalid | ~i_stall;

    // pivot = diag - carry, saturated; must be strictly positive
    assign w_piv     = sat_diff({r_diag[DATA_WIDTH-1], r_diag} - {r_carry[DATA_WIDTH-1], r_carry});
    assign w_piv_pos = ~w_piv[DATA_WIDTH-1] & (w_piv != '0);

    // shared divider: real part first, then imaginary
    assign w_div_num = (r_state == ST_DIM_GO) ? r_ei : r_er;

    tlf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_pivot),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // shared multiplier: f*re, then g*im, accumulated into the next carry
    assign w_mac_a = w_sel_im ? r_mi : r_mr;
    assign w_mac_b = w_sel_im ? r_ei : r_er;

    tlf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (w_mac_a),
        .i_b     (w_mac_b),
        .o_sum   (w_sum)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_PIVOT;
                end
            end
            ST_PIVOT: begin
                if (r_failed == '0 && w_piv_pos && !r_last) begin
                    n_state = ST_DRE_GO;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_DRE_GO:   n_state = ST_DRE_WAIT;
            ST_DRE_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_DIM_GO;
                end
            end
            ST_DIM_GO:   n_state = ST_DIM_WAIT;
            ST_DIM_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_MUL_RE;
                end
            end
            ST_MUL_RE:   n_state = ST_MUL_IM;
            ST_MUL_IM:   n_state = ST_ACC;
            ST_ACC:      n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs to the shared units
    always_comb begin
        w_div_start = 1'b0;
        w_sel_im    = 1'b0;
        w_mac_ctl   = '0;
        unique case (r_state)
            ST_DRE_GO, ST_DIM_GO: begin
                w_div_start = 1'b1;
            end
            ST_MUL_RE: begin
                w_mac_ctl.mul_en = 1'b1;
            end
            ST_MUL_IM: begin
                // load the imaginary product while the real one starts the sum
                w_sel_im          = 1'b1;
                w_mac_ctl.mul_en  = 1'b1;
                w_mac_ctl.acc_en  = 1'b1;
                w_mac_ctl.acc_clr = 1'b1;
            end
            ST_ACC: begin
                w_mac_ctl.acc_en = 1'b1;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    // control and recurrence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ovalid    <= 1'b0;
            r_carry     <= '0;
            r_row_count <= '0;
            r_failed    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EMIT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (w_accept) begin
                // 1-based row number, saturating
                if (!(&r_row_count)) begin
                    r_row_count <= r_row_count + 1'b1;
                end
            end
            if (r_state == ST_PIVOT && r_failed == '0 && !w_piv_pos) begin
                r_failed <= r_row_count;
            end
            if (r_state == ST_EMIT && w_out_free) begin
                if (r_last) begin
                    // end of matrix clears the recurrence
                    r_carry     <= '0;
                    r_row_count <= '0;
                    r_failed    <= '0;
                end else if (r_status == STAT_OK) begin
                    r_carry <= w_sum;
                end
            end
        end
    end

    // row payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_diag <= i_diag_in;
            r_er   <= i_offdiag_re;
            r_ei   <= i_offdiag_im;
            r_last <= i_last;
            r_mr   <= i_last ? '0 : i_offdiag_re;
            r_mi   <= i_last ? '0 : i_offdiag_im;
        end
        if (r_state == ST_PIVOT) begin
            if (r_failed != '0) begin
                r_pivot  <= r_diag;
                r_status <= STAT_SKIP;
            end else begin
                r_pivot  <= w_piv;
                r_status <= w_piv_pos ? STAT_OK : STAT_FAIL;
            end
        end
        if (r_state == ST_DRE_WAIT && w_div_done) begin
            r_mr <= w_quot;
        end
        if (r_state == ST_DIM_WAIT && w_div_done) begin
            r_mi <= w_quot;
        end
        if (r_state == ST_EMIT && w_out_free) begin
            r_o_pivot  <= r_pivot;
            r_o_mr     <= r_mr;
            r_o_mi     <= r_mi;
            r_o_status <= r_status;
            r_o_fail   <= r_failed;
            r_o_last   <= r_last;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_pivot_out  = r_o_pivot;
    assign o_mult_re    = r_o_mr;
    assign o_mult_im    = r_o_mi;
    assign o_status     = r_o_status;
    assign o_fail_index = r_o_fail;
    assign o_last_out   = r_o_last;

`ifndef SYNTHESIS
    // a failed or skipped row always reports where the failure happened
    a_fail_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_FAIL || o_status == STAT_SKIP) |-> o_fail_index != '0)
        else $error("failure reported without a failing row");

    // one row at a time: a transfer closes the input
    a_one_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_stall)
        else $error("input open right after a transfer");

    // divisions only run on a positive pivot with no earlier failure
    a_div_pivot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRE_WAIT || r_state == ST_DIM_WAIT) |->
            (!r_pivot[DATA_WIDTH-1] && r_pivot != '0 && r_failed == '0))
        else $error("divide started on a bad pivot");

    // the divider answers only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DRE_WAIT || r_state == ST_DIM_WAIT))
        else $error("divider result with nobody waiting");
`endif

endmodule

// ===== hw/rtl/tlf_div.sv =====
module tlf_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  tlf_pkg::t_data i_num,
    input  tlf_pkg::t_data i_den,
    output logic          o_done,
    output tlf_pkg::t_data o_quot
);
    import tlf_pkg::*;

    // restoring divider, one quotient bit per cycle
    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_neg;
    logic [NUM_W-1:0]      r_q;
    logic [DATA_WIDTH:0]   r_rem;
    logic [DATA_WIDTH-1:0] r_den;
    t_data                 r_quot;

    logic [DATA_WIDTH-1:0] w_abs;
    logic [DATA_WIDTH:0]   w_shift;
    logic [DATA_WIDTH:0]   w_diff;
    t_data                 w_sat;

    assign w_abs   = i_num[DATA_WIDTH-1] ? (~i_num + 1'b1) : i_num;
    assign w_shift = {r_rem[DATA_WIDTH-1:0], r_q[NUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    // final sign and saturation of the quotient magnitude
    always_comb begin
        if (r_neg) begin
            if (r_q > NUM_W'({1'b1, {(DATA_WIDTH-1){1'b0}}})) begin
                w_sat = DATA_MIN;
            end else begin
                w_sat = t_data'(~r_q[DATA_WIDTH-1:0] + 1'b1);
            end
        end else begin
            if (r_q > NUM_W'({1'b0, {(DATA_WIDTH-1){1'b1}}})) begin
                w_sat = DATA_MAX;
            end else begin
                w_sat = t_data'(r_q[DATA_WIDTH-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= {w_abs, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_neg <= i_num[DATA_WIDTH-1];
            r_den <= i_den;
        end else if (r_busy && r_cnt != '0) begin
            if (!w_diff[DATA_WIDTH]) begin
                r_rem <= w_diff;
                r_q   <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_q   <= {r_q[NUM_W-2:0], 1'b0};
            end
        end
        if (r_busy && r_cnt == '0) begin
            r_quot <= w_sat;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hw/rtl/tlf_mac.sv =====
module tlf_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlf_pkg::t_mac_ctl i_ctl,
    input  tlf_pkg::t_data    i_a,
    input  tlf_pkg::t_data    i_b,
    output tlf_pkg::t_data    o_sum
);
    import tlf_pkg::*;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_base;

    assign w_prod = i_a * i_b;
    assign w_base = i_ctl.acc_clr ? '0 : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            // floor shift of the registered product, then accumulate
            r_acc <= w_base + ACC_W'(r_prod >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_prod;
        end
    end

    assign o_sum = sat_acc(r_acc);

endmodule

// ===== bench/tridiagonal_ldlh_factor_stream_tb.sv =====
`timescale 1ns / 100ps

module tridiagonal_ldlh_factor_stream_tb;
    import tlf_pkg::*;

    // run sizing
    localparam int ROW_TARGET   = 1650;       // least number of rows offered, directed plus random
    localparam int HOLD_CYCLES  = 1200;       // long output hold-off, fills the block
    localparam int HOLD_AT      = 300;        // results received before the hold-off starts
    localparam int CALM_LO      = 700;        // window with no idling on either side
    localparam int CALM_HI      = 1000;
    localparam int IDLE_PCT     = 28;
    localparam int DRAIN_CYCLES = 300;        // wait after the last result for stray results
    localparam int CYCLE_LIMIT  = 1_000_000;

    // one row of the plan: stimulus, plus an expected result where it is written out
    typedef struct packed {
        t_data   diag;
        t_data   off_re;
        t_data   off_im;
        logic    last;
        logic    typed;
        t_data   exp_pivot;
        t_data   exp_re;
        t_data   exp_im;
        t_status exp_status;
        t_index  exp_fail_index;
    } plan_row_t;

    // one factored row as it leaves the block
    typedef struct packed {
        t_data   pivot;
        t_data   mult_re;
        t_data   mult_im;
        t_status status;
        t_index  fail_index;
        logic    last;
    } factor_result_t;

    // directed rows; expected values are typed in only where they are plain to see,
    // the rest go through the predictor
    localparam int N_DIRECTED = 20;
    localparam plan_row_t DIRECTED [N_DIRECTED] = '{
        // single-row matrices: zero pivot, most negative pivot, largest pivot
        '{32'sd0, 32'sd5, -32'sd7, 1'b1,
          1'b1, 32'sd0, 32'sd0, 32'sd0, STAT_FAIL, 16'd1},
        '{DATA_MIN, DATA_MAX, DATA_MIN, 1'b1,
          1'b1, DATA_MIN, 32'sd0, 32'sd0, STAT_FAIL, 16'd1},
        '{DATA_MAX, DATA_MIN, DATA_MAX, 1'b1,
          1'b1, DATA_MAX, 32'sd0, 32'sd0, STAT_OK, 16'd0},
        // pivot of one lsb: both quotients saturate, carry saturates to max
        '{32'sd1, DATA_MAX, DATA_MIN, 1'b0,
          1'b1, 32'sd1, DATA_MAX, DATA_MIN, STAT_OK, 16'd0},
        // max diagonal minus saturated carry gives a zero pivot on row 2
        '{DATA_MAX, 32'sd0, -32'sd1, 1'b0,
          1'b1, 32'sd0, 32'sd0, -32'sd1, STAT_FAIL, 16'd2},
        // rows after the failure pass straight through
        '{DATA_MIN, DATA_MIN, DATA_MAX, 1'b0,
          1'b1, DATA_MIN, DATA_MIN, DATA_MAX, STAT_SKIP, 16'd2},
        '{32'sd123, 32'sd77, 32'sd88, 1'b1,
          1'b1, 32'sd123, 32'sd0, 32'sd0, STAT_SKIP, 16'd2},
        // 1.0 with off-diagonal (0.5, -0.5): carry 0.5
        '{32'sh0001_0000, 32'sh0000_8000, -32'sh0000_8000, 1'b0,
          1'b0, '0, '0, '0, STAT_OK, '0},
        // most negative diagonal minus a positive carry saturates low
        '{DATA_MIN, 32'sd1, 32'sd2, 1'b0,
          1'b1, DATA_MIN, 32'sd1, 32'sd2, STAT_FAIL, 16'd2},
        '{32'sd5, -32'sd5, 32'sd6, 1'b1,
          1'b1, 32'sd5, 32'sd0, 32'sd0, STAT_SKIP, 16'd2},
        // ordinary chain, then a quotient that truncates toward zero
        '{32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0,
          1'b0, '0, '0, '0, STAT_OK, '0},
        '{32'sh0003_0000, -32'sh0001_8000, 32'sh0000_8000, 1'b0,
          1'b0, '0, '0, '0, STAT_OK, '0},
        '{32'sh0003_0000, -32'sd1, 32'sd1, 1'b0,
          1'b0, '0, '0, '0, STAT_OK, '0},
        '{DATA_MAX, DATA_MIN, DATA_MAX, 1'b0,
          1'b0, '0, '0, '0, STAT_OK, '0},
        '{32'sh0004_0000, 32'sh0000_1234, -32'sh0000_5678, 1'b1,
          1'b0, '0, '0, '0, STAT_OK, '0},
        // large multipliers, then a last row whose pivot fails
        '{32'sh0001_0000, DATA_MAX, DATA_MAX, 1'b0,
          1'b0, '0, '0, '0, STAT_OK, '0},
        '{DATA_MAX, 32'sd3, 32'sd4, 1'b1,
          1'b0, '0, '0, '0, STAT_OK, '0},
        '{-32'sd1, -32'sd1, -32'sd1, 1'b1,
          1'b0, '0, '0, '0, STAT_OK, '0},
        // zero off-diagonal leaves no carry
        '{32'sh0001_0000, 32'sd0, 32'sd0, 1'b0,
          1'b0, '0, '0, '0, STAT_OK, '0},
        '{32'sd1, DATA_MIN, DATA_MIN, 1'b1,
          1'b0, '0, '0, '0, STAT_OK, '0}
    };

    logic    i_clk        = 1'b0;
    logic    i_rst_n      = 1'b0;
    logic    i_valid      = 1'b0;
    logic    o_stall;
    t_data   i_diag_in    = '0;
    t_data   i_offdiag_re = '0;
    t_data   i_offdiag_im = '0;
    logic    i_last       = 1'b0;
    logic    o_valid;
    logic    i_stall      = 1'b0;
    t_data   o_pivot_out;
    t_data   o_mult_re;
    t_data   o_mult_im;
    t_status o_status;
    t_index  o_fail_index;
    logic    o_last_out;

    plan_row_t      row_plan[$];
    factor_result_t pending_factors[$];

    // predictor state, mirrors the block's carry, row counter and failure mark
    t_data  ldl_carry    = '0;
    t_index ldl_row      = '0;
    t_index ldl_fail_row = '0;

    int   next_row  = 0;      // index of the row being offered
    int   rows_out  = 0;      // result transfers seen
    int   errors    = 0;
    int   cycle_cnt = 0;
    logic long_hold = 1'b0;

    tridiagonal_ldlh_factor_stream uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_diag_in    (i_diag_in),
        .i_offdiag_re (i_offdiag_re),
        .i_offdiag_im (i_offdiag_im),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pivot_out  (o_pivot_out),
        .o_mult_re    (o_mult_re),
        .o_mult_im    (o_mult_im),
        .o_status     (o_status),
        .o_fail_index (o_fail_index),
        .o_last_out   (o_last_out)
    );

    always #2 i_clk = ~i_clk;

    // clamp a wide intermediate to the data range
    function automatic t_data clamp_data(input longint x);
        if (x > longint'(DATA_MAX)) return DATA_MAX;
        if (x < longint'(DATA_MIN)) return DATA_MIN;
        return t_data'(x);
    endfunction

    // fixed-point quotient (num << FRAC_BITS) / den, truncated toward zero
    function automatic t_data fixed_quotient(input t_data num, input t_data den);
        longint scaled;
        scaled = longint'(num) * (longint'(1) << FRAC_BITS);
        return clamp_data(scaled / longint'(den));
    endfunction

    // factor one row: pivot, multiplier and carry for the next row
    function automatic factor_result_t factor_row(input t_data d, input t_data re,
                                                  input t_data im, input logic last);
        factor_result_t r;
        t_index         row;
        t_data          piv;
        longint         prod_re;
        longint         prod_im;
        row = (ldl_row == '1) ? ldl_row : ldl_row + 1'b1;   // row number saturates
        ldl_row = row;
        r.mult_re = last ? '0 : re;
        r.mult_im = last ? '0 : im;
        if (ldl_fail_row != '0) begin
            // already failed: pass the row through
            piv = d;
            r.status = STAT_SKIP;
        end else begin
            piv = clamp_data(longint'(d) - longint'(ldl_carry));
            if (piv <= 0) begin
                ldl_fail_row = row;
                r.status = STAT_FAIL;
            end else begin
                r.status = STAT_OK;
                if (!last) begin
                    r.mult_re = fixed_quotient(re, piv);
                    r.mult_im = fixed_quotient(im, piv);
                    // products shift arithmetically before they are summed
                    prod_re = (longint'(r.mult_re) * longint'(re)) >>> FRAC_BITS;
                    prod_im = (longint'(r.mult_im) * longint'(im)) >>> FRAC_BITS;
                    ldl_carry = clamp_data(prod_re + prod_im);
                end
            end
        end
        r.pivot = piv;
        r.fail_index = ldl_fail_row;
        r.last = last;
        // last row closes the matrix
        if (last) begin
            ldl_carry = '0;
            ldl_row = '0;
            ldl_fail_row = '0;
        end
        return r;
    endfunction

    // field values mostly at corners (min, max, 0, +1, -1), else a random value
    function automatic t_data corner_value();
        case ($urandom_range(0, 5))
            0: return DATA_MIN;
            1: return DATA_MAX;
            2: return '0;
            3: return t_data'(1);
            4: return t_data'(-1);
            default: return t_data'($urandom);
        endcase
    endfunction

    // directed table first, then whole random matrices until the target is reached
    task automatic build_rows();
        int    kind;
        int    len;
        int    shift;
        int    broken;
        t_data d;
        t_data re;
        t_data im;
        t_data span;
        foreach (DIRECTED[k]) row_plan.push_back(DIRECTED[k]);
        while (row_plan.size() < ROW_TARGET) begin
            kind   = $urandom_range(0, 99);
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            shift  = $urandom_range(0, 13);
            broken = (kind >= 70 && kind < 82) ? $urandom_range(0, len - 1) : -1;
            for (int k = 0; k < len; k++) begin
                if (kind < 82) begin
                    // diagonally dominant at one scale per matrix: pivots stay positive
                    d    = t_data'($urandom_range(32'h1_0000, 32'h2_0000)) <<< shift;
                    span = d >>> 2;
                    re   = t_data'($urandom_range(0, span));
                    im   = t_data'($urandom_range(0, span));
                    if ($urandom_range(0, 1)) re = -re;
                    if ($urandom_range(0, 1)) im = -im;
                    // one weak diagonal can break the matrix partway
                    if (k == broken) begin
                        d = t_data'($urandom_range(0, 32'h2_0000)) - t_data'(32'h1_8000);
                    end
                end else if (kind < 95) begin
                    d  = t_data'($urandom);
                    re = t_data'($urandom);
                    im = t_data'($urandom);
                end else begin
                    d  = corner_value();
                    re = corner_value();
                    im = corner_value();
                end
                row_plan.push_back(plan_row_t'{d, re, im, k == len - 1, 1'b0,
                                               '0, '0, '0, STAT_OK, '0});
            end
        end
    endtask

    task automatic flag_error(input string msg);
        errors++;
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    endtask

    task automatic check_field(input string name, input logic [DATA_WIDTH-1:0] got,
                               input logic [DATA_WIDTH-1:0] want);
        if (got !== want) begin
            flag_error($sformatf("result %0d %s got %h want %h", rows_out, name, got, want));
        end
    endtask

    // row sender: predicts each transfer, holds a stalled row, idles at random
    always @(posedge i_clk) begin
        factor_result_t want;
        plan_row_t      nxt;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                want = factor_row(i_diag_in, i_offdiag_re, i_offdiag_im, i_last);
                if (row_plan[next_row].typed) begin
                    want.pivot      = row_plan[next_row].exp_pivot;
                    want.mult_re    = row_plan[next_row].exp_re;
                    want.mult_im    = row_plan[next_row].exp_im;
                    want.status     = row_plan[next_row].exp_status;
                    want.fail_index = row_plan[next_row].exp_fail_index;
                end
                pending_factors.push_back(want);
                next_row++;
            end
            // a stalled row stays on the port untouched
            if (!(i_valid && o_stall)) begin
                if (next_row < row_plan.size() &&
                    ((next_row >= CALM_LO && next_row < CALM_HI) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = row_plan[next_row];
                    i_valid      <= 1'b1;
                    i_diag_in    <= nxt.diag;
                    i_offdiag_re <= nxt.off_re;
                    i_offdiag_im <= nxt.off_im;
                    i_last       <= nxt.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver: compares each transfer against the oldest prediction
    always @(posedge i_clk) begin
        factor_result_t want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_factors.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with nothing outstanding", rows_out));
                end else begin
                    want = pending_factors.pop_front();
                    check_field("pivot_out", o_pivot_out, want.pivot);
                    check_field("mult_re", o_mult_re, want.mult_re);
                    check_field("mult_im", o_mult_im, want.mult_im);
                    check_field("status", DATA_WIDTH'(o_status), DATA_WIDTH'(want.status));
                    check_field("fail_index", DATA_WIDTH'(o_fail_index),
                                DATA_WIDTH'(want.fail_index));
                    check_field("last_out", DATA_WIDTH'(o_last_out), DATA_WIDTH'(want.last));
                end
                rows_out++;
            end
            if (long_hold) begin
                i_stall <= 1'b1;
            end else if (rows_out >= CALM_LO && rows_out < CALM_HI) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // one long output hold-off while rows keep coming, so the input backs up
    initial begin
        wait (rows_out >= HOLD_AT);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        build_rows();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // all rows transferred and every prediction matched by a result
        while (next_row < row_plan.size() || pending_factors.size() != 0) @(posedge i_clk);
        // stray results would show up here
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
